### rtl/sorted_wakeup_timer_queue_macros.svh
// ----------------------------------------------------------------------------
// Sorted wakeup timer queue: assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_WAKEUP_TIMER_QUEUE_MACROS_SVH
`define SORTED_WAKEUP_TIMER_QUEUE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define SWTQ_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define SWTQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/swtq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted wakeup timer queue: package
// Field widths, status and operation codes, and sequencer states.
// ----------------------------------------------------------------------------
package swtq_pkg;

   // Field widths
   localparam int TICK_W      = 63;
   localparam int ID_PORT_W   = 8;
   localparam int DUR_W       = 32;
   localparam int PRIO_W      = 6;
   localparam int STATUS_W    = 3;
   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 136;
   localparam int RSP_PAD_W   = RSP_TDATA_W - ID_PORT_W - 2 * TICK_W;

   // Parameter defaults
   localparam int QUEUE_DEPTH_DEF    = 16;
   localparam int THREAD_ID_BITS_DEF = 8;

   // Operation carried on req_tuser
   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_SLEEP = 1'b1;

   // Result status carried on rsp_tuser
   typedef enum logic [STATUS_W-1:0] {
      ST_WOKEN       = 3'd0,
      ST_NOTHING_DUE = 3'd1,
      ST_QUEUED      = 3'd2,
      ST_IGNORED     = 3'd3,
      ST_DROPPED     = 3'd4
   } status_type;

   // Sequencer states
   typedef enum logic [3:0] {
      S_IDLE,
      S_SLEEP,
      S_INS_START,
      S_INS_CMP,
      S_INS_WR,
      S_TICK_START,
      S_TICK_CMP,
      S_WAKE_RD,
      S_WAKE_OUT,
      S_EMIT
   } state_type;

endpackage

### rtl/swtq_mem.sv
// ----------------------------------------------------------------------------
// Sorted wakeup timer queue: entry memory
// One write port and one registered read port holding wake tick,
// priority and thread id for each queue slot.
// ----------------------------------------------------------------------------
module swtq_mem
   import swtq_pkg::*;
#(
   parameter int DEPTH   = QUEUE_DEPTH_DEF,
   parameter int ID_BITS = THREAD_ID_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [TICK_W-1:0]        wr_wake,
   input  logic [PRIO_W-1:0]        wr_prio,
   input  logic [ID_BITS-1:0]       wr_thread,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [TICK_W-1:0]        rd_wake,
   output logic [PRIO_W-1:0]        rd_prio,
   output logic [ID_BITS-1:0]       rd_thread
);

   logic [TICK_W-1:0]  mem_wake   [DEPTH];
   logic [PRIO_W-1:0]  mem_prio   [DEPTH];
   logic [ID_BITS-1:0] mem_thread [DEPTH];

   // Write one slot
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_wake[wr_addr]   <= wr_wake;
         mem_prio[wr_addr]   <= wr_prio;
         mem_thread[wr_addr] <= wr_thread;
      end
   end

   // Read one slot, hold the data until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_wake   <= mem_wake[rd_addr];
         rd_prio   <= mem_prio[rd_addr];
         rd_thread <= mem_thread[rd_addr];
      end
   end

endmodule

### rtl/sorted_wakeup_timer_queue.sv
// ----------------------------------------------------------------------------
// Sorted wakeup timer queue
// Tick counter plus a bounded queue of sleeping threads kept in wake order
// (earlier tick first, higher priority first on ties, arrival order last).
// ----------------------------------------------------------------------------
// Channel  Dir  Ports            Content
// req      in   tvalid/tready    tuser: operation; tdata: thread_id,
//                                sleep_ticks, priority_req
// rsp      out  tvalid/tready    tuser: status; tlast: last; tdata: woken_id,
//                                wake_tick, now_tick
//
// Sleep: S_SLEEP, S_INS_START, S_INS_CMP per entry compared, S_INS_WR, then
// S_EMIT loads the result; an ignored request leaves from S_SLEEP, a dropped
// one from S_INS_START, straight to S_EMIT. Tick: S_TICK_START, S_TICK_CMP per
// entry scanned, S_WAKE_RD and S_WAKE_OUT per woken thread, or S_EMIT for nothing due.
// All ordering goes through a single wake-tick comparator and the single
// read port of the entry memory.
// The queue is a ring in memory; a wakeup advances its head pointer.
// Synchronous reset clears the counter, the queue and the result valid flag.
// req_tready is high only while the sequencer is idle; a stalled rsp holds
// the sequencer at its next result.
// ----------------------------------------------------------------------------
module sorted_wakeup_timer_queue
   import swtq_pkg::*;
#(
   parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF,
   parameter int THREAD_ID_BITS = THREAD_ID_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [7:0] thread_id, [39:8] sleep_ticks, [45:40] priority_req, [47:46] zero
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // [0] operation
   input  logic                   req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [7:0] woken_id, [70:8] wake_tick, [133:71] now_tick, [135:134] zero
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // [2:0] status
   output logic [STATUS_W-1:0]    rsp_tuser,
   output logic                   rsp_tlast
);

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W = IDX_W + 1;
   localparam logic [CNT_W-1:0] FULL = CNT_W'(QUEUE_DEPTH);
   localparam logic [CNT_W-1:0] ONE  = CNT_W'(1);
   localparam logic [CNT_W-1:0] TWO  = CNT_W'(2);

   // Ring slot of queue position pos
   function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] head,
                                             input logic [CNT_W-1:0] pos);
      logic [SUM_W-1:0] sum;
      sum = {1'b0, head} + SUM_W'(pos);
      if (sum >= SUM_W'(QUEUE_DEPTH)) begin
         sum = sum - SUM_W'(QUEUE_DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

   state_type                 state_ff, state_in;
   logic [TICK_W-1:0]         tick_ff, tick_in;
   logic [IDX_W-1:0]          head_ff, head_in;
   logic [CNT_W-1:0]          occ_ff, occ_in;
   logic [CNT_W-1:0]          idx_ff, idx_in;
   logic [THREAD_ID_BITS-1:0] id_ff, id_in;
   logic [DUR_W-1:0]          dur_ff, dur_in;
   logic [PRIO_W-1:0]         prio_ff, prio_in;
   logic [TICK_W-1:0]         wake_ff, wake_in;
   status_type                st_ff, st_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   status_type                rsp_status_ff, rsp_status_in;
   logic [ID_PORT_W-1:0]      rsp_id_ff, rsp_id_in;
   logic [TICK_W-1:0]         rsp_wake_ff, rsp_wake_in;
   logic [TICK_W-1:0]         rsp_now_ff, rsp_now_in;
   logic                      rsp_last_ff, rsp_last_in;

   logic                      req_xfer;
   logic                      tick_xfer;
   logic                      in_wake_out;
   logic                      out_free;
   logic                      dur_pos;
   logic [TICK_W:0]           wake_sum;
   logic [TICK_W-1:0]         tick_next;

   logic                      mem_wr_en;
   logic [IDX_W-1:0]          mem_wr_addr;
   logic [TICK_W-1:0]         mem_wr_wake;
   logic [PRIO_W-1:0]         mem_wr_prio;
   logic [THREAD_ID_BITS-1:0] mem_wr_thread;
   logic                      mem_rd_en;
   logic [IDX_W-1:0]          mem_rd_addr;
   logic [TICK_W-1:0]         mem_rd_wake;
   logic [PRIO_W-1:0]         mem_rd_prio;
   logic [THREAD_ID_BITS-1:0] mem_rd_thread;

   logic [TICK_W-1:0]         cmp_key;
   logic                      cmp_lt;
   logic                      cmp_eq;
   logic                      ins_move;
   logic                      tick_due;

   swtq_mem #(
      .DEPTH   (QUEUE_DEPTH),
      .ID_BITS (THREAD_ID_BITS)
   ) u_mem (
      .clock     (clock),
      .wr_en     (mem_wr_en),
      .wr_addr   (mem_wr_addr),
      .wr_wake   (mem_wr_wake),
      .wr_prio   (mem_wr_prio),
      .wr_thread (mem_wr_thread),
      .rd_en     (mem_rd_en),
      .rd_addr   (mem_rd_addr),
      .rd_wake   (mem_rd_wake),
      .rd_prio   (mem_rd_prio),
      .rd_thread (mem_rd_thread)
   );

   // Handshake helpers
   assign req_tready  = (state_ff == S_IDLE);
   assign req_xfer    = req_tvalid && req_tready;
   assign tick_xfer   = req_xfer && (req_tuser == OP_TICK);
   assign in_wake_out = (state_ff == S_WAKE_OUT);
   assign out_free    = !rsp_valid_ff || rsp_tready;

   // Advance the tick counter, wrapping at the top of its range
   assign tick_next = tick_ff + TICK_W'(1);

   // Saturating wake tick of a positive duration
   assign dur_pos  = !dur_ff[DUR_W-1] && (dur_ff != '0);
   assign wake_sum = {1'b0, tick_ff} + (TICK_W + 1)'(dur_ff[DUR_W-2:0]);

   // Shared comparator: new wake tick while inserting, tick count while scanning
   assign cmp_key  = (state_ff == S_TICK_CMP) ? tick_ff : wake_ff;
   assign cmp_lt   = cmp_key < mem_rd_wake;
   assign cmp_eq   = cmp_key == mem_rd_wake;
   assign ins_move = cmp_lt || (cmp_eq && (prio_ff > mem_rd_prio));
   assign tick_due = !cmp_lt;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               state_in = (req_tuser == OP_SLEEP) ? S_SLEEP : S_TICK_START;
            end
         end
         S_SLEEP: begin
            state_in = dur_pos ? S_INS_START : S_EMIT;
         end
         S_INS_START: begin
            if (occ_ff == FULL) begin
               state_in = S_EMIT;
            end else if (occ_ff == '0) begin
               state_in = S_INS_WR;
            end else begin
               state_in = S_INS_CMP;
            end
         end
         S_INS_CMP: begin
            state_in = (ins_move && (idx_ff != ONE)) ? S_INS_CMP : S_INS_WR;
         end
         S_INS_WR: begin
            state_in = S_EMIT;
         end
         S_TICK_START: begin
            state_in = (occ_ff == '0) ? S_EMIT : S_TICK_CMP;
         end
         S_TICK_CMP: begin
            if (tick_due && ((idx_ff + ONE) < occ_ff)) begin
               state_in = S_TICK_CMP;
            end else if (tick_due || (idx_ff != '0)) begin
               state_in = S_WAKE_RD;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_WAKE_RD: begin
            state_in = S_WAKE_OUT;
         end
         S_WAKE_OUT: begin
            if (out_free) begin
               state_in = (idx_ff == ONE) ? S_IDLE : S_WAKE_RD;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Datapath, memory control and result loading
   always_comb begin
      tick_in       = tick_ff;
      head_in       = head_ff;
      occ_in        = occ_ff;
      idx_in        = idx_ff;
      id_in         = id_ff;
      dur_in        = dur_ff;
      prio_in       = prio_ff;
      wake_in       = wake_ff;
      st_in         = st_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_wake_in   = rsp_wake_ff;
      rsp_now_in    = rsp_now_ff;
      rsp_last_in   = rsp_last_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = slot(head_ff, idx_ff);
      mem_wr_wake   = mem_rd_wake;
      mem_wr_prio   = mem_rd_prio;
      mem_wr_thread = mem_rd_thread;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = head_ff;
      unique case (state_ff)
         S_IDLE: begin
            // Capture the request; a tick advances the counter at once
            if (req_xfer) begin
               id_in   = THREAD_ID_BITS'(req_tdata[7:0]);
               dur_in  = req_tdata[39:8];
               prio_in = req_tdata[45:40];
               if (req_tuser == OP_TICK) begin
                  tick_in = tick_next;
               end
            end
         end
         S_SLEEP: begin
            wake_in = wake_sum[TICK_W] ? '1 : wake_sum[TICK_W-1:0];
            if (!dur_pos) begin
               st_in = ST_IGNORED;
            end
         end
         S_INS_START: begin
            // Start at the tail and walk toward the head
            idx_in = occ_ff;
            if (occ_ff == FULL) begin
               st_in = ST_DROPPED;
            end else if (occ_ff != '0) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = slot(head_ff, occ_ff - ONE);
            end
         end
         S_INS_CMP: begin
            // Move the later entry back one place and fetch the one before it
            if (ins_move) begin
               mem_wr_en = 1'b1;
               idx_in    = idx_ff - ONE;
               if (idx_ff != ONE) begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = slot(head_ff, idx_ff - TWO);
               end
            end
         end
         S_INS_WR: begin
            mem_wr_en     = 1'b1;
            mem_wr_wake   = wake_ff;
            mem_wr_prio   = prio_ff;
            mem_wr_thread = id_ff;
            occ_in        = occ_ff + ONE;
            st_in         = ST_QUEUED;
         end
         S_TICK_START: begin
            idx_in = '0;
            if (occ_ff == '0) begin
               st_in = ST_NOTHING_DUE;
            end else begin
               mem_rd_en = 1'b1;
            end
         end
         S_TICK_CMP: begin
            // Count due entries from the head
            if (tick_due) begin
               idx_in = idx_ff + ONE;
               if ((idx_ff + ONE) < occ_ff) begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = slot(head_ff, idx_ff + ONE);
               end
            end else if (idx_ff == '0) begin
               st_in = ST_NOTHING_DUE;
            end
         end
         S_WAKE_RD: begin
            mem_rd_en = 1'b1;
         end
         S_WAKE_OUT: begin
            // Release the head entry
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_WOKEN;
               rsp_id_in     = ID_PORT_W'(mem_rd_thread);
               rsp_wake_in   = mem_rd_wake;
               rsp_now_in    = tick_ff;
               rsp_last_in   = (idx_ff == ONE);
               head_in       = slot(head_ff, ONE);
               occ_in        = occ_ff - ONE;
               idx_in        = idx_ff - ONE;
            end
         end
         S_EMIT: begin
            // Single result of the staged status
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = st_ff;
               rsp_now_in    = tick_ff;
               rsp_last_in   = 1'b1;
               rsp_id_in     = ID_PORT_W'(id_ff);
               rsp_wake_in   = '0;
               case (st_ff) inside
                  ST_QUEUED, ST_DROPPED: begin
                     rsp_wake_in = wake_ff;
                  end
                  ST_NOTHING_DUE: begin
                     rsp_id_in = '0;
                  end
                  default: begin
                     rsp_wake_in = '0;
                  end
               endcase
            end
         end
         default: begin
            idx_in = idx_ff;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tick_ff      <= '0;
         head_ff      <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tick_ff      <= tick_in;
         head_ff      <= head_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      id_ff         <= id_in;
      dur_ff        <= dur_in;
      prio_ff       <= prio_in;
      wake_ff       <= wake_in;
      st_ff         <= st_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_wake_ff   <= rsp_wake_in;
      rsp_now_ff    <= rsp_now_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // Result channel
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_now_ff, rsp_wake_ff, rsp_id_ff};

   // Checks
   `include "sorted_wakeup_timer_queue_macros.svh"

   `SWTQ_ASSERT_SAME(a_occ_bound, 1'b1, occ_ff <= FULL, "occupancy beyond depth")
   `SWTQ_ASSERT_SAME(a_ins_room, state_ff == S_INS_WR, occ_ff < FULL, "insert into full queue")
   `SWTQ_ASSERT_SAME(a_wake_nonempty, in_wake_out, (occ_ff != '0) && (idx_ff != '0), "empty wakeup")
   `SWTQ_ASSERT_NEXT(a_tick_adv, tick_xfer, tick_ff == $past(tick_next), "tick not advanced")

endmodule

### verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted wakeup timer queue: testbench
// Drives ticks and sleep requests into the queue and mirrors each accepted
// request in a local copy of the tick counter and the sorted sleeper list.
// Every result transfer is checked field by field against the oldest
// predicted result. The run covers directed ordering, ignore, drop and
// full-burst cases, then random traffic under three pacing phases.
// ----------------------------------------------------------------------------
module tb
   import swtq_pkg::*;
();

   typedef struct {
      logic [TICK_W-1:0]    wake;
      logic [PRIO_W-1:0]    prio;
      logic [ID_PORT_W-1:0] id;
   } sleeper_type;

   typedef struct {
      status_type           status;
      logic [ID_PORT_W-1:0] id;
      logic [TICK_W-1:0]    wake;
      logic [TICK_W-1:0]    now;
      logic                 last;
   } timer_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   req_tuser = OP_TICK;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [STATUS_W-1:0]    rsp_tuser;
   logic                   rsp_tlast;

   // Local copy of the block state
   logic [TICK_W-1:0]      tick_now = '0;
   sleeper_type            sleepers[$];
   timer_result_type       pending_timer_results[$];

   int send_idle_pct = 13;
   int recv_idle_pct = 64;
   int error_count   = 0;
   int requests_sent = 0;
   int results_seen  = 0;
   int woken_seen    = 0;
   int dropped_seen  = 0;
   int ignored_seen  = 0;

   sorted_wakeup_timer_queue i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Stall the result channel at the current receiver rate
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Hard limit on the run
   initial begin
      #5_000_000;
      $error("timeout with %0d results still outstanding", pending_timer_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic void push_result(input status_type status,
                                       input logic [ID_PORT_W-1:0] id,
                                       input logic [TICK_W-1:0] wake,
                                       input logic last);
      timer_result_type r;
      r.status = status;
      r.id     = id;
      r.wake   = wake;
      r.now    = tick_now;
      r.last   = last;
      pending_timer_results.push_back(r);
   endfunction

   // Apply one accepted request to the local queue and record its results
   function automatic void predict_timer_step(input logic op,
                                              input logic [ID_PORT_W-1:0] id,
                                              input logic [DUR_W-1:0] dur,
                                              input logic [PRIO_W-1:0] prio);
      logic [TICK_W:0] sum;
      sleeper_type     fresh;
      int              pos;
      int              due;
      if (op == OP_SLEEP) begin
         if (dur == '0 || dur[DUR_W-1]) begin
            push_result(ST_IGNORED, id, '0, 1'b1);
            return;
         end
         // saturate the wake tick at the top of the counter range
         sum = {1'b0, tick_now} + {{(TICK_W + 1 - DUR_W){1'b0}}, dur};
         fresh.wake = sum[TICK_W] ? '1 : sum[TICK_W-1:0];
         fresh.prio = prio;
         fresh.id   = id;
         if (sleepers.size() >= QUEUE_DEPTH_DEF) begin
            push_result(ST_DROPPED, id, fresh.wake, 1'b1);
            return;
         end
         // earlier tick first, then higher priority, then arrival order
         pos = sleepers.size();
         for (int i = 0; i < sleepers.size(); i++) begin
            if (fresh.wake < sleepers[i].wake ||
                (fresh.wake == sleepers[i].wake && fresh.prio > sleepers[i].prio)) begin
               pos = i;
               break;
            end
         end
         sleepers.insert(pos, fresh);
         push_result(ST_QUEUED, id, fresh.wake, 1'b1);
      end else begin
         tick_now = tick_now + 1'b1;
         due = 0;
         while (due < sleepers.size() && sleepers[due].wake <= tick_now) due++;
         if (due == 0) begin
            push_result(ST_NOTHING_DUE, '0, '0, 1'b1);
         end else begin
            for (int i = 0; i < due; i++) begin
               push_result(ST_WOKEN, sleepers[0].id, sleepers[0].wake, i == due - 1);
               void'(sleepers.pop_front());
            end
         end
      end
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         error_count++;
      end
   endfunction

   // Compare each result transfer with the oldest prediction
   always @(posedge clock) begin
      timer_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (pending_timer_results.size() == 0) begin
            $error("unexpected result: status %0d id 0x%0h", rsp_tuser, rsp_tdata[7:0]);
            error_count++;
         end else begin
            want = pending_timer_results.pop_front();
            check_field("status", 64'(want.status), 64'(rsp_tuser));
            check_field("woken_id", 64'(want.id), 64'(rsp_tdata[ID_PORT_W-1:0]));
            check_field("wake_tick", 64'(want.wake), 64'(rsp_tdata[ID_PORT_W +: TICK_W]));
            check_field("now_tick", 64'(want.now),
                        64'(rsp_tdata[ID_PORT_W + TICK_W +: TICK_W]));
            check_field("last", 64'(want.last), 64'(rsp_tlast));
            case (want.status)
               ST_WOKEN:   woken_seen++;
               ST_DROPPED: dropped_seen++;
               ST_IGNORED: ignored_seen++;
               default:    ;
            endcase
         end
      end
   end

   // Offer one request, hold it until the transfer, then predict it
   task automatic send_request(input logic op, input logic [ID_PORT_W-1:0] id,
                               input logic [DUR_W-1:0] dur, input logic [PRIO_W-1:0] prio);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {2'b00, prio, dur, id};
      do @(posedge clock); while (!req_tready);
      predict_timer_step(op, id, dur, prio);
      requests_sent++;
      @(negedge clock);
   endtask

   task automatic set_pacing(input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
   endtask

   // Tick on an empty queue, then the non-positive durations
   task automatic test_empty_and_ignored();
      send_request(OP_TICK, '0, '0, '0);
      send_request(OP_SLEEP, 8'h00, 32'h0000_0000, 6'h00);
      send_request(OP_SLEEP, 8'hFF, 32'h8000_0000, 6'h3F);
   endtask

   // Equal wake ticks sorted by priority, equal entries in arrival order
   task automatic test_ordering();
      send_request(OP_SLEEP, 8'h10, 32'd2, 6'd5);
      send_request(OP_SLEEP, 8'h11, 32'd2, 6'd40);
      send_request(OP_SLEEP, 8'h10, 32'd2, 6'd5);
      send_request(OP_SLEEP, 8'h12, 32'd1, 6'd0);
      send_request(OP_TICK, '0, '0, '0);
      send_request(OP_TICK, '0, '0, '0);
   endtask

   // Fill the queue, drop the longest sleep, then wake everything at once
   task automatic test_queue_full();
      for (int i = 0; i < QUEUE_DEPTH_DEF; i++) begin
         send_request(OP_SLEEP, ID_PORT_W'(8'hE0 + i), 32'd1, PRIO_W'((i * 37) % 64));
      end
      send_request(OP_SLEEP, 8'hFF, 32'h7FFF_FFFF, 6'h3F);
      send_request(OP_TICK, '0, '0, '0);
   endtask

   // Mixed ticks and sleeps with mostly short durations so entries cycle
   task automatic test_random_traffic(input int count);
      logic [DUR_W-1:0]  dur;
      logic [PRIO_W-1:0] prio;
      int                roll;
      for (int n = 0; n < count; n++) begin
         prio = ($urandom_range(0, 1) == 0) ? PRIO_W'($urandom_range(0, 3))
                                            : PRIO_W'($urandom_range(0, 63));
         if ($urandom_range(0, 99) < 45) begin
            send_request(OP_TICK, ID_PORT_W'($urandom_range(0, 255)), $urandom(), prio);
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 6)
               dur = '0;
            else if (roll < 20)
               dur = $urandom() | 32'h8000_0000;
            else if (sleepers.size() >= QUEUE_DEPTH_DEF)
               dur = $urandom() & 32'h7FFF_FFFF;
            else if (roll < 25)
               dur = $urandom_range(13, 60);
            else
               dur = $urandom_range(1, 12);
            send_request(OP_SLEEP, ID_PORT_W'($urandom_range(0, 255)), dur, prio);
         end
      end
   endtask

   // Release the request channel and let every result drain
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_timer_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      set_pacing(13, 64);
      test_empty_and_ignored();
      test_ordering();
      test_queue_full();
      test_random_traffic(151);

      set_pacing(64, 13);
      test_random_traffic(151);

      set_pacing(0, 0);
      test_random_traffic(151);

      drain_results();
      $display("Covered %0d requests and %0d results under three pacing phases:",
               requests_sent, results_seen);
      $display("%0d wakeups, %0d dropped on a full queue, %0d ignored sleeps.",
               woken_seen, dropped_seen, ignored_seen);
      if (error_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

### sim.f
+incdir+rtl
rtl/swtq_pkg.sv
rtl/swtq_mem.sv
rtl/sorted_wakeup_timer_queue.sv
verif/tb.sv
